FILE: sv/hmfo_pkg.sv
// Shared types, constants and saturating helpers for the hammer/mass oscillator.
package hmfo_pkg;

  localparam int DataW = 32;
  localparam int AddrW = 4;

  typedef logic signed [DataW-1:0] word_t;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MASS_FREQ   = 2'd0;
  localparam logic [1:0] REG_HAMMER_STIF = 2'd1;
  localparam logic [1:0] REG_MASS_RATIO  = 2'd2;

  localparam word_t MASS_FREQ_RESET    = 32'sh3000_0000;
  localparam word_t HAMMER_INIT_LAST   = 32'shffe0_8af0;
  localparam word_t HAMMER_INIT_BEFORE = 32'shfeb8_51ec;
  localparam word_t WORD_MAX           = 32'sh7fff_ffff;
  localparam word_t WORD_MIN           = 32'sh8000_0000;

  // clamp a 33-bit signed value into the 32-bit range
  function automatic word_t sat33(input logic signed [DataW:0] v);
    if (v[DataW] != v[DataW-1]) begin
      sat33 = v[DataW] ? WORD_MIN : WORD_MAX;
    end else begin
      sat33 = v[DataW-1:0];
    end
  endfunction

  // x * 16 with saturation
  function automatic word_t shl4_sat(input word_t x);
    if (x[DataW-1:DataW-5] == 5'b00000 || x[DataW-1:DataW-5] == 5'b11111) begin
      shl4_sat = {x[DataW-5:0], 4'b0000};
    end else begin
      shl4_sat = x[DataW-1] ? WORD_MIN : WORD_MAX;
    end
  endfunction

endpackage

FILE: sv/hammer_mass_fd_oscillator_unit.sv
// Hammer-and-mass finite-difference oscillator: one shared multiplier and adder under a sequencer.
//
// Each accepted transfer advances the model one audio tick and yields one transfer
// holding the new mass and hammer positions (Q1.31). An item passes through an
// accept step, eight sequencer steps through the single shared 32x32
// fractional multiplier and the single shared saturating adder (five multiplies,
// seven add/subtract steps), and one write-back step. The write-back waits while a
// previous result is still held and stalled; a new item may be accepted while the
// last result waits. in_restart reloads the initial positions before the tick.
// Registers: 0x0 mass_frequency, 0x4 hammer_stiffness, 0x8 mass_ratio; writes are
// expected only while the block is idle.
module hammer_mass_fd_oscillator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_restart,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hmfo_pkg::DataW-1:0]  out_mass_position,
  output logic [hmfo_pkg::DataW-1:0]  out_hammer_position,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hmfo_pkg::AddrW-1:0]  paddr,
  input  logic [hmfo_pkg::DataW-1:0]  pwdata,
  output logic [hmfo_pkg::DataW-1:0]  prdata,
  output logic                        pready
);
  import hmfo_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_D    = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_M3   = 4'd4;
  localparam logic [3:0] S_M4   = 4'd5;
  localparam logic [3:0] S_M5   = 4'd6;
  localparam logic [3:0] S_M6   = 4'd7;
  localparam logic [3:0] S_M7   = 4'd8;
  localparam logic [3:0] S_WB   = 4'd9;

  logic [3:0] state_r, state_nxt;

  word_t freq_r, stif_r, ratio_r;
  word_t m1_r, m2_r, h1_r, h2_r;
  word_t d_r, p_r, f_r, ha_r, ma_r;
  logic  gt_r;
  logic  out_valid_r;
  word_t out_mass_r, out_hammer_r;

  logic  in_xfer, cfg_wr, wb_go;
  word_t mul_a, mul_b, mul_res;
  logic signed [2*DataW-1:0] mul_full;
  word_t add_a, add_b, add_res;
  logic  add_sub;
  logic signed [DataW:0] add_full;
  word_t m0, h0;

  assign pready   = 1'b1;
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign wb_go    = (state_r == S_WB) && !(out_valid_r && out_stall);

  assign out_valid           = out_valid_r;
  assign out_mass_position   = out_mass_r;
  assign out_hammer_position = out_hammer_r;

  always_comb begin
    unique case (paddr[3:2])
      REG_MASS_FREQ:   prdata = freq_r;
      REG_HAMMER_STIF: prdata = stif_r;
      REG_MASS_RATIO:  prdata = ratio_r;
      default:         prdata = '0;
    endcase
  end

  // shared fractional multiplier: floor(a*b / 2^31), saturated
  always_comb begin
    unique case (state_r)
      S_M1:    begin mul_a = d_r;     mul_b = d_r;  end
      S_M2:    begin mul_a = p_r;     mul_b = d_r;  end
      S_M3:    begin mul_a = stif_r;  mul_b = p_r;  end
      S_M4:    begin mul_a = freq_r;  mul_b = m1_r; end
      S_M5:    begin mul_a = ratio_r; mul_b = f_r;  end
      default: begin mul_a = d_r;     mul_b = d_r;  end
    endcase
  end
  assign mul_full = mul_a * mul_b;
  assign mul_res  = sat33(mul_full[2*DataW-1:DataW-1]);

  // shared saturating adder
  always_comb begin
    unique case (state_r)
      S_D:     begin add_a = h1_r;         add_b = m1_r;         add_sub = 1'b1; end
      S_M1:    begin add_a = h1_r >>> 3;   add_b = h2_r >>> 4;   add_sub = 1'b1; end
      S_M2:    begin add_a = m1_r >>> 3;   add_b = m2_r >>> 4;   add_sub = 1'b1; end
      S_M4:    begin add_a = ha_r;         add_b = f_r;          add_sub = 1'b1; end
      S_M5:    begin add_a = ma_r;         add_b = p_r >>> 4;    add_sub = 1'b1; end
      S_M6:    begin add_a = ma_r;         add_b = p_r;          add_sub = 1'b0; end
      S_M7:    begin add_a = '0;           add_b = ha_r;         add_sub = 1'b1; end
      default: begin add_a = '0;           add_b = '0;           add_sub = 1'b0; end
    endcase
  end
  assign add_full = add_sub ? ({add_a[DataW-1], add_a} - {add_b[DataW-1], add_b})
                            : ({add_a[DataW-1], add_a} + {add_b[DataW-1], add_b});
  assign add_res  = sat33(add_full);

  assign m0 = shl4_sat(ma_r);
  assign h0 = shl4_sat(ha_r);

  always_comb begin
    unique case (state_r)
      S_IDLE:  state_nxt = in_xfer ? S_D : S_IDLE;
      S_D:     state_nxt = S_M1;
      S_M1:    state_nxt = S_M2;
      S_M2:    state_nxt = S_M3;
      S_M3:    state_nxt = S_M4;
      S_M4:    state_nxt = S_M5;
      S_M5:    state_nxt = S_M6;
      S_M6:    state_nxt = S_M7;
      S_M7:    state_nxt = S_WB;
      S_WB:    state_nxt = wb_go ? S_IDLE : S_WB;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control, configuration and position state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      freq_r      <= MASS_FREQ_RESET;
      stif_r      <= '0;
      ratio_r     <= '0;
      m1_r        <= '0;
      m2_r        <= '0;
      h1_r        <= HAMMER_INIT_LAST;
      h2_r        <= HAMMER_INIT_BEFORE;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_MASS_FREQ:   freq_r  <= pwdata;
          REG_HAMMER_STIF: stif_r  <= pwdata;
          REG_MASS_RATIO:  ratio_r <= pwdata;
          default: ;
        endcase
      end
      if (in_xfer && in_restart) begin
        m1_r <= '0;
        m2_r <= '0;
        h1_r <= HAMMER_INIT_LAST;
        h2_r <= HAMMER_INIT_BEFORE;
      end else if (wb_go) begin
        m2_r <= m1_r;
        m1_r <= m0;
        h2_r <= h1_r;
        h1_r <= h0;
      end
      if (wb_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath scratch registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_D: begin
        d_r  <= add_res;
        // exact difference positive means hammer ahead of mass
        gt_r <= !add_full[DataW] && (add_full != '0);
      end
      S_M1: begin p_r <= mul_res; ha_r <= add_res; end
      S_M2: begin p_r <= mul_res; ma_r <= add_res; end
      S_M3: f_r <= gt_r ? mul_res : '0;
      S_M4: begin p_r <= mul_res; ha_r <= add_res; end
      S_M5: begin p_r <= mul_res; ma_r <= add_res; end
      S_M6: ma_r <= add_res;
      S_M7: ha_r <= add_res;
      default: ;
    endcase
    if (wb_go) begin
      out_mass_r   <= m0;
      out_hammer_r <= h0;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_D)
    else $error("accepted item did not start the sequence");

  a_no_force_when_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_M4) && !gt_r |-> f_r == '0)
    else $error("contact force nonzero while hammer is not ahead");

  a_writeback_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    wb_go |=> out_valid_r && (state_r == S_IDLE) && (out_mass_r == $past(m0)))
    else $error("write-back did not present the result");

  a_wb_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) && out_valid_r && out_stall |=> state_r == S_WB)
    else $error("write-back overran a held result");

endmodule

FILE: dv/hmfo_tick_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the hammer/mass oscillator: predicts each tick and checks every result transfer.
module hmfo_tick_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_restart,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [hmfo_pkg::DataW-1:0] out_mass_position,
  input  logic [hmfo_pkg::DataW-1:0] out_hammer_position,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [hmfo_pkg::AddrW-1:0] paddr,
  input  logic [hmfo_pkg::DataW-1:0] pwdata,
  output int                         failures,
  output int                         pending
);
  import hmfo_pkg::*;

  typedef struct packed {
    word_t mass;
    word_t hammer;
  } positions_t;

  word_t freq_coeff;
  word_t stiffness;
  word_t force_ratio;
  word_t mass_last;
  word_t mass_prev;
  word_t hammer_last;
  word_t hammer_prev;

  positions_t expected_positions[$];

  function automatic word_t clamp_word(input longint v);
    if (v > longint'(WORD_MAX)) return WORD_MAX;
    if (v < longint'(WORD_MIN)) return WORD_MIN;
    return word_t'(v);
  endfunction

  // fractional multiply, floor rounding; only -1 * -1 clamps
  function automatic word_t q31_mul(input word_t a, input word_t b);
    longint prod;
    prod = longint'(a) * longint'(b);
    return clamp_word(prod >>> 31);
  endfunction

  function automatic word_t q31_add(input word_t a, input word_t b);
    return clamp_word(longint'(a) + longint'(b));
  endfunction

  function automatic word_t q31_sub(input word_t a, input word_t b);
    return clamp_word(longint'(a) - longint'(b));
  endfunction

  function automatic word_t q31_neg(input word_t a);
    return clamp_word(-longint'(a));
  endfunction

  function automatic word_t q31_shl4(input word_t a);
    return clamp_word(longint'(a) * 16);
  endfunction

  function automatic positions_t next_positions(input logic restart);
    word_t gap;
    word_t contact;
    word_t mass_new;
    word_t hammer_new;
    word_t mass_shr3;
    word_t mass_shr4;
    word_t hammer_shr3;
    word_t hammer_shr4;
    word_t spring_term;
    positions_t res;
    if (restart) begin
      mass_last   = '0;
      mass_prev   = '0;
      hammer_last = HAMMER_INIT_LAST;
      hammer_prev = HAMMER_INIT_BEFORE;
    end
    // contact force only while the hammer is ahead of the mass
    if (hammer_last > mass_last) begin
      gap     = q31_sub(hammer_last, mass_last);
      contact = q31_mul(stiffness, q31_mul(q31_mul(gap, gap), gap));
    end else begin
      contact = '0;
    end
    hammer_shr3 = hammer_last >>> 3;
    hammer_shr4 = hammer_prev >>> 4;
    mass_shr3   = mass_last >>> 3;
    mass_shr4   = mass_prev >>> 4;
    spring_term = q31_mul(freq_coeff, mass_last) >>> 4;
    hammer_new = q31_shl4(q31_neg(q31_sub(q31_sub(hammer_shr3, hammer_shr4), contact)));
    mass_new   = q31_shl4(q31_add(q31_sub(q31_sub(mass_shr3, mass_shr4), spring_term),
                                  q31_mul(force_ratio, contact)));
    mass_prev   = mass_last;
    mass_last   = mass_new;
    hammer_prev = hammer_last;
    hammer_last = hammer_new;
    res.mass   = mass_new;
    res.hammer = hammer_new;
    return res;
  endfunction

  always @(posedge clk) begin
    positions_t want;
    if (!rst_n) begin
      freq_coeff  = MASS_FREQ_RESET;
      stiffness   = '0;
      force_ratio = '0;
      mass_last   = '0;
      mass_prev   = '0;
      hammer_last = HAMMER_INIT_LAST;
      hammer_prev = HAMMER_INIT_BEFORE;
      expected_positions.delete();
      failures = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MASS_FREQ:   freq_coeff  = pwdata;
          REG_HAMMER_STIF: stiffness   = pwdata;
          REG_MASS_RATIO:  force_ratio = pwdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_positions.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: result transfer with nothing expected: mass %h hammer %h",
                     $time, out_mass_position, out_hammer_position);
        end else begin
          want = expected_positions.pop_front();
          if (out_mass_position !== want.mass || out_hammer_position !== want.hammer) begin
            failures++;
            if (failures <= 10)
              $display("%0t: mismatch: mass exp %h got %h, hammer exp %h got %h", $time,
                       want.mass, out_mass_position, want.hammer, out_hammer_position);
          end
        end
      end
      if (in_valid && !in_stall) expected_positions.push_back(next_positions(in_restart));
    end
    pending = expected_positions.size();
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the hammer/mass oscillator unit.
module testbench;
  import hmfo_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int WatchdogLimit = 3000;
  localparam int LongHold = 300;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_restart = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [DataW-1:0] out_mass_position;
  logic [DataW-1:0] out_hammer_position;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  int failures;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_hold = 0;
  int quiet_cycles = 0;

  hammer_mass_fd_oscillator_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_mass_position  (out_mass_position),
    .out_hammer_position(out_hammer_position),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  hmfo_tick_checker tick_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_mass_position  (out_mass_position),
    .out_hammer_position(out_hammer_position),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .pready             (pready),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .failures           (failures),
    .pending            (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stall, or a forced hold-off counted down here
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      out_stall = 1'b1;
      stall_hold--;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("[hammer_mass_fd_oscillator_unit] ERROR");
      $finish;
    end
  end

  task automatic send_tick(input logic restart);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid   = 1'b0;
      in_restart = 1'($urandom_range(1));
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_restart = restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input word_t value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
  endtask

  task automatic set_coeffs(input word_t freq, input word_t stif, input word_t ratio);
    write_reg(REG_MASS_FREQ, freq);
    write_reg(REG_HAMMER_STIF, stif);
    write_reg(REG_MASS_RATIO, ratio);
  endtask

  function automatic word_t pick_coeff();
    word_t raw;
    raw = word_t'($urandom);
    case ($urandom_range(5))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return raw;
      4: return raw >>> $urandom_range(2, 20);
      default: return word_t'($urandom_range(32'h7fff_ffff));
    endcase
  endfunction

  initial begin
    int run_left;
    logic tick_restart;
    run_left = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset coefficients: free hammer, no contact force on the mass
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    drain();

    // hard contact, negative spring
    set_coeffs(WORD_MIN, WORD_MAX, WORD_MAX);
    send_tick(1'b1);
    repeat (7) send_tick(1'b0);
    drain();

    // all coefficients at -1, plus a write to the unmapped slot
    set_coeffs(WORD_MIN, WORD_MIN, WORD_MIN);
    write_reg(REG_UNUSED, 32'h5a5a_a5a5);
    send_tick(1'b1);
    repeat (7) send_tick(1'b0);
    drain();

    set_coeffs(WORD_MAX, WORD_MAX, WORD_MIN);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      set_coeffs(pick_coeff(), pick_coeff(), pick_coeff());
      if ($urandom_range(3) == 0) write_reg(REG_UNUSED, $urandom);
      @(posedge clk);
      case (phase / 4)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // back-pressure: result side holds off while ticks keep coming
      if (phase == 8 || phase == 2) stall_hold = LongHold;
      for (int n = 0; n < 125; n++) begin
        if (run_left == 0) begin
          tick_restart = 1'b1;
          run_left = $urandom_range(1, 60);
        end else begin
          tick_restart = ($urandom_range(99) < 3);
          run_left--;
        end
        if ($urandom_range(199) == 0 || (phase == 9 && n == 60)) drain();
        send_tick(tick_restart);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("[hammer_mass_fd_oscillator_unit] OK");
    end else begin
      $display("[hammer_mass_fd_oscillator_unit] ERROR");
    end
    $finish;
  end

endmodule
